// ===== design/pulse_speed_slew_average_macros.svh =====
// Assertion macros for the pulse speedometer block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PULSE_SPEED_SLEW_AVERAGE_MACROS_SVH
`define PULSE_SPEED_SLEW_AVERAGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psa_pkg.sv =====
// Shared types and constants for the pulse speedometer block.
// No dependencies; used by psa_div and pulse_speed_slew_average.
package psa_pkg;

  // field and register widths
  localparam int CNT_W     = 16;
  localparam int SPD_W     = 16;
  localparam int RATIO_W   = 16;
  localparam int PPT_W     = 8;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // divider widths: 36000 * 16-bit count fits 32 bits, ratio * pulses fits 24
  localparam int NUM_W      = 32;
  localparam int DEN_W      = RATIO_W + PPT_W;
  localparam int DIV_STEP_W = $clog2(NUM_W);

  // averaging ring
  localparam int AVG_DEPTH = 4;
  localparam int AVG_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  // arithmetic constants
  localparam logic [CNT_W-1:0] LOW_MAX     = 16'd2;
  localparam logic [15:0]      SPEED_SCALE = 16'd36000;
  localparam logic [SPD_W-1:0] SPEED_SAT   = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP   = 2'd3;

  // register reset values
  localparam logic [RATIO_W-1:0] RST_WHEEL_RATIO = 16'd2200;
  localparam logic [PPT_W-1:0]   RST_PULSES_PT   = 8'd1;
  localparam logic [STEP_W-1:0]  RST_FALL_STEP   = 16'd50;
  localparam logic [STEP_W-1:0]  RST_RISE_STEP   = 16'd50;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } psa_div_stat_t;

endpackage

// ===== design/psa_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on psa_pkg for widths and the status struct.
module psa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psa_pkg::NUM_W-1:0]    num,
  input  logic [psa_pkg::DEN_W-1:0]    den,
  output psa_pkg::psa_div_stat_t       stat,
  output logic [psa_pkg::SPD_W-1:0]    quo
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [psa_pkg::DIV_STEP_W-1:0]  step_r, step_nxt;
  logic [psa_pkg::NUM_W-1:0]       qn_r, qn_nxt;
  logic [psa_pkg::DEN_W-1:0]       rem_r, rem_nxt;
  logic [psa_pkg::DEN_W-1:0]       den_r, den_nxt;
  logic [psa_pkg::DEN_W:0]         rem_sh;
  logic                            ge;

  // shift in next numerator bit, trial subtract
  assign rem_sh = {rem_r, qn_r[psa_pkg::NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (busy_r) begin
      qn_nxt  = {qn_r[psa_pkg::NUM_W-2:0], ge};
      rem_nxt = ge ? psa_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                   : rem_sh[psa_pkg::DEN_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == psa_pkg::DIV_STEP_W'(psa_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = qn_r[psa_pkg::SPD_W-1:0];

endmodule

// ===== design/pulse_speed_slew_average.sv =====
// Pulse speedometer: one pulse count per measuring window in, one filtered
// speed in 0.1 km/h out.
//
// in_*  : stream slave, tdata[15:0] = pulse_count.
// out_* : stream master, tdata[15:0] = speed. Exactly one word per input word.
// cfg_* : write port, cfg_addr 0 wheel ratio, 1 pulses per turn, 2 fall step,
//         3 rise step. Write only while the block is idle.
//
// The history is updated at the accepting edge. The sequencer then forms
// the dividend and divisor, launches the divider, waits through the 32
// steps of the bit-serial divider and its done flag, applies the slew
// limit and ring update, and loads the output register. A zero divisor
// skips the divider and goes straight to the slew limit. in_tready is
// high only while the sequencer is idle, so a new word is taken only once
// the previous result is in the output register; it can be taken while
// that result still waits there for the receiver. If the receiver stalls,
// a finished result waits in the sequencer until the output register is
// free.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// history, the averaging ring and out_tvalid, and idles the sequencer.
`include "pulse_speed_slew_average_macros.svh"

module pulse_speed_slew_average (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] pulse_count
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] speed
  // configuration
  input  logic                               cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [psa_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_SLEW   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // configuration registers
  logic [psa_pkg::RATIO_W-1:0] ratio_r;
  logic [psa_pkg::PPT_W-1:0]   ppt_r;
  logic [psa_pkg::STEP_W-1:0]  fall_r;
  logic [psa_pkg::STEP_W-1:0]  rise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= psa_pkg::RST_WHEEL_RATIO;
      ppt_r   <= psa_pkg::RST_PULSES_PT;
      fall_r  <= psa_pkg::RST_FALL_STEP;
      rise_r  <= psa_pkg::RST_RISE_STEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        psa_pkg::REG_WHEEL_RATIO: ratio_r <= cfg_wdata;
        psa_pkg::REG_PULSES_PT:   ppt_r   <= cfg_wdata[psa_pkg::PPT_W-1:0];
        psa_pkg::REG_FALL_STEP:   fall_r  <= cfg_wdata;
        psa_pkg::REG_RISE_STEP:   rise_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [2:0] state_r, state_nxt;

  // low-speed history
  logic [psa_pkg::CNT_W-1:0] hist0_r, hist0_nxt, hist1_r, hist1_nxt;
  logic                      low_idx_r, low_idx_nxt;
  logic                      low_primed_r, low_primed_nxt;
  logic [psa_pkg::CNT_W-1:0] freq_r, freq_nxt;

  // divider operands and raw speed
  logic [psa_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [psa_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [psa_pkg::SPD_W-1:0] raw_r, raw_nxt;

  // averaging ring
  logic [psa_pkg::SPD_W-1:0]     ring_r [psa_pkg::AVG_DEPTH];
  logic [psa_pkg::AVG_IDX_W-1:0] avg_idx_r, avg_idx_nxt;
  logic                          avg_primed_r, avg_primed_nxt;
  logic [psa_pkg::SPD_W-1:0]     prev_r, prev_nxt;
  logic [psa_pkg::SPD_W-1:0]     sum_r, sum_nxt;
  logic [psa_pkg::SPD_W-1:0]     res_r, res_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [psa_pkg::SPD_W-1:0] out_data_r, out_data_nxt;

  // slew limiter and ring helpers
  logic [psa_pkg::SPD_W-1:0]     nv;
  logic [psa_pkg::SPD_W-1:0]     sum_upd;
  logic [psa_pkg::AVG_IDX_W-1:0] idx_inc;
  logic                          ring_fill, ring_wr;
  logic [17:0]                   cnt_x5;

  psa_pkg::psa_div_stat_t    div_stat;
  logic [psa_pkg::SPD_W-1:0] div_quo;
  logic                      div_start;

  psa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign div_start = (state_r == ST_LAUNCH) && (den_r != '0);
  assign cnt_x5    = {in_tdata, 2'b00} + {2'b00, in_tdata};

  // slew limit against the last stored sample
  always_comb begin
    nv = raw_r;
    if (prev_r > raw_r) begin
      if ((prev_r - raw_r) > fall_r) nv = prev_r - fall_r;
    end else begin
      if ((raw_r - prev_r) > rise_r) nv = prev_r + rise_r;
    end
  end

  // running ring sum, modulo 16 bits
  assign sum_upd = sum_r - ring_r[avg_idx_r] + nv;
  assign idx_inc = (avg_idx_r == psa_pkg::AVG_IDX_W'(psa_pkg::AVG_DEPTH - 1)) ? '0
                 : avg_idx_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    hist0_nxt      = hist0_r;
    hist1_nxt      = hist1_r;
    low_idx_nxt    = low_idx_r;
    low_primed_nxt = low_primed_r;
    freq_nxt       = freq_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    raw_nxt        = raw_r;
    avg_idx_nxt    = avg_idx_r;
    avg_primed_nxt = avg_primed_r;
    prev_nxt       = prev_r;
    sum_nxt        = sum_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ring_fill      = 1'b0;
    ring_wr        = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata <= psa_pkg::LOW_MAX) begin
            if (!low_idx_r && !low_primed_r) begin
              hist0_nxt      = in_tdata;
              hist1_nxt      = in_tdata;
              low_primed_nxt = 1'b1;
              low_idx_nxt    = 1'b1;
            end else begin
              if (low_idx_r) hist1_nxt = in_tdata;
              else           hist0_nxt = in_tdata;
              low_idx_nxt = ~low_idx_r;
            end
            // entries hold at most two, so the sum cannot wrap
            freq_nxt = hist0_nxt + hist1_nxt;
          end else begin
            low_idx_nxt    = 1'b0;
            low_primed_nxt = 1'b0;
            freq_nxt       = cnt_x5[psa_pkg::CNT_W-1:0];
          end
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        num_nxt   = psa_pkg::SPEED_SCALE * freq_r;
        den_nxt   = ratio_r * ppt_r;
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (den_r == '0) begin
          raw_nxt   = psa_pkg::SPEED_SAT;
          state_nxt = ST_SLEW;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          raw_nxt   = div_quo;
          state_nxt = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (!avg_primed_r) begin
          // first sample fills the ring and passes through
          ring_fill      = 1'b1;
          prev_nxt       = raw_r;
          sum_nxt        = psa_pkg::SPD_W'(raw_r * psa_pkg::AVG_DEPTH);
          avg_idx_nxt    = psa_pkg::AVG_IDX_W'(1 % psa_pkg::AVG_DEPTH);
          avg_primed_nxt = 1'b1;
          res_nxt        = raw_r;
        end else begin
          ring_wr     = 1'b1;
          prev_nxt    = nv;
          sum_nxt     = sum_upd;
          avg_idx_nxt = idx_inc;
          res_nxt     = psa_pkg::SPD_W'(sum_upd / psa_pkg::AVG_DEPTH);
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hist0_r      <= '0;
      hist1_r      <= '0;
      low_idx_r    <= 1'b0;
      low_primed_r <= 1'b0;
      avg_idx_r    <= '0;
      avg_primed_r <= 1'b0;
      prev_r       <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hist0_r      <= hist0_nxt;
      hist1_r      <= hist1_nxt;
      low_idx_r    <= low_idx_nxt;
      low_primed_r <= low_primed_nxt;
      avg_idx_r    <= avg_idx_nxt;
      avg_primed_r <= avg_primed_nxt;
      prev_r       <= prev_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // ring entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psa_pkg::AVG_DEPTH; i++) ring_r[i] <= '0;
    end else if (ring_fill) begin
      for (int i = 0; i < psa_pkg::AVG_DEPTH; i++) ring_r[i] <= raw_r;
    end else if (ring_wr) begin
      ring_r[avg_idx_r] <= nv;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    freq_r     <= freq_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    raw_r      <= raw_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `PSA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "input taken while a word is in flight")
  `PSA_ASSERT_NOW(a_div_running, state_r == ST_DIV, div_stat.busy || div_stat.done,
    "sequencer waits on an idle divider")
  `PSA_ASSERT_NEXT(a_fin_loads, (state_r == ST_FIN) && (!out_valid_r || out_tready),
    out_valid_r && (state_r == ST_IDLE), "finished result not loaded into output")

endmodule
